@@ hdl/uvp_pkg.sv @@
// Shared types and constants for the UUID text parser.
package uvp_pkg;

    localparam int IN_W    = 8;
    localparam int TIME_W  = 60;
    localparam int CLK_W   = 14;
    localparam int NODE_W  = 48;
    localparam int STAT_W  = 2;
    localparam int TDIG_W  = 64;
    localparam int CDIG_W  = 16;
    localparam int CNT_W   = 4;
    localparam int OUT_W   = 128;

    localparam logic [CNT_W-1:0] TIME_LAST  = 4'd15;
    localparam logic [CNT_W-1:0] CLOCK_LAST = 4'd3;
    localparam logic [CNT_W-1:0] NODE_LAST  = 4'd11;

    localparam logic [3:0] VERSION_ONE  = 4'h1;
    localparam logic [1:0] VARIANT_STD  = 2'b10;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_SYNTAX  = 2'd1,
        ST_VERSION = 2'd2,
        ST_VARIANT = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        PH_TIME    = 6'b000001,
        PH_TIMEEND = 6'b000010,
        PH_CLOCK   = 6'b000100,
        PH_CLKEND  = 6'b001000,
        PH_NODE    = 6'b010000,
        PH_SWALLOW = 6'b100000
    } t_phase;

    typedef struct packed {
        logic                is_digit;
        logic [3:0]          value;
        logic                is_term;
    } t_char;

    typedef struct packed {
        logic                valid;
        t_status             status;
        logic [TIME_W-1:0]   time_value;
        logic [CLK_W-1:0]    clock_sequence;
        logic [NODE_W-1:0]   node_id;
    } t_result;

endpackage

@@ hdl/uvp_decode.sv @@
// Maps one input byte to a hex digit value and flags the terminator.
module uvp_decode (
    input  logic [uvp_pkg::IN_W-1:0] i_byte,
    output uvp_pkg::t_char           o_char
);
    import uvp_pkg::*;

    logic [7:0] v0;
    logic [7:0] v1;

    always_comb begin
        v0 = i_byte - 8'h30;
        if (v0 > 8'd48) begin
            v1 = v0 - 8'd39;
        end else if (v0 > 8'd15) begin
            v1 = v0 - 8'd7;
        end else begin
            v1 = v0;
        end
        o_char.is_term  = (i_byte == '0);
        o_char.is_digit = (v1 <= 8'd15);
        o_char.value    = v1[3:0];
    end

endmodule

@@ hdl/uvp_fsm.sv @@
// Parse state, digit accumulators and result formation for one byte.
module uvp_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  uvp_pkg::t_char   i_char,
    output uvp_pkg::t_result o_result
);
    import uvp_pkg::*;

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [TDIG_W-1:0]    r_time,  n_time;
    logic [CDIG_W-1:0]    r_clock, n_clock;
    logic [NODE_W-1:0]    r_node,  n_node;

    t_phase               eff_phase;
    logic                 done;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_time   = r_time;
        n_clock  = r_clock;
        n_node   = r_node;
        o_result = '0;
        eff_phase = r_phase;
        done     = 1'b0;

        if (i_char.is_term) begin
            // terminator: syntax error unless a result was already given
            o_result.valid  = (r_phase != PH_SWALLOW) && (r_phase != PH_TIMEEND ||
                              1'b1);
            case (r_phase)
                PH_TIME, PH_TIMEEND, PH_CLOCK, PH_CLKEND, PH_NODE:
                    o_result.valid = 1'b1;
                default: o_result.valid = 1'b0;
            endcase
            o_result.status = ST_SYNTAX;
            n_phase = PH_TIME;
            n_count = '0;
            n_time  = '0;
            n_clock = '0;
            n_node  = '0;
            done    = 1'b1;
        end else if (r_phase == PH_TIMEEND) begin
            if (r_time[15:12] != VERSION_ONE) begin
                o_result.valid  = 1'b1;
                o_result.status = ST_VERSION;
                n_phase = PH_SWALLOW;
                done    = 1'b1;
            end else begin
                eff_phase = PH_CLOCK;
                n_count   = '0;
            end
        end else if (r_phase == PH_CLKEND) begin
            if (r_clock[15:14] != VARIANT_STD) begin
                o_result.valid  = 1'b1;
                o_result.status = ST_VARIANT;
                n_phase = PH_SWALLOW;
                done    = 1'b1;
            end else begin
                eff_phase = PH_NODE;
                n_count   = '0;
            end
        end

        if (!done) begin
            n_phase = eff_phase;
            if (i_char.is_digit) begin
                case (eff_phase)
                    PH_TIME: begin
                        n_time = {r_time[TDIG_W-5:0], i_char.value};
                        if (n_count >= TIME_LAST) begin
                            n_phase = PH_TIMEEND;
                            n_count = '0;
                        end else begin
                            n_count = n_count + 1'b1;
                        end
                    end
                    PH_CLOCK: begin
                        n_clock = {r_clock[CDIG_W-5:0], i_char.value};
                        if (n_count >= CLOCK_LAST) begin
                            n_phase = PH_CLKEND;
                            n_count = '0;
                        end else begin
                            n_count = n_count + 1'b1;
                        end
                    end
                    PH_NODE: begin
                        n_node = {r_node[NODE_W-5:0], i_char.value};
                        if (n_count >= NODE_LAST) begin
                            n_phase = PH_SWALLOW;
                            n_count = '0;
                            o_result.valid          = 1'b1;
                            o_result.status         = ST_OK;
                            // timestamp: high 12 bits, then middle 16, then low 32
                            o_result.time_value     = {r_time[11:0], r_time[31:16],
                                                       r_time[63:32]};
                            o_result.clock_sequence = r_clock[CLK_W-1:0];
                            o_result.node_id        = n_node;
                        end else begin
                            n_count = n_count + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TIME;
            r_count <= '0;
            r_time  <= '0;
            r_clock <= '0;
            r_node  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_time  <= n_time;
            r_clock <= n_clock;
            r_node  <= n_node;
        end
    end

endmodule

@@ hdl/uuid_v1_text_parser.sv @@
// Top level of the streaming UUID version-1 text parser.
// Usage:
//   Slave channel takes one character per item in tdata[7:0]; a zero byte
//   ends the string. Master channel gives at most one result per string:
//   status in tuser, time, clock sequence and node in tdata.
//   A result is given on the twelfth node digit (status ok), on a failed
//   version or variant check, or on a terminator that arrives before the
//   string is complete (syntax error). After a result on a nonzero byte,
//   bytes are dropped up to and including the next terminator.
// Timing:
//   One item per cycle sustained while no result waits for i_m_axis_tready.
//   An item is captured in the input register when it is accepted and is
//   parsed into the output register when the parser advances; o_m_axis_tvalid
//   comes from that register. The parse state updates once per item, which
//   sets the rate.
// Reset and stall:
//   Reset empties both registers and returns the parser to the time field.
//   While a result waits for i_m_axis_tready, the input register still holds
//   one further item; then o_s_axis_tready drops until the result is taken.
module uuid_v1_text_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [uvp_pkg::IN_W-1:0]   i_s_axis_tdata,   // [7:0] char_code
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [uvp_pkg::OUT_W-1:0]  o_m_axis_tdata,   // [59:0] time_value,
                                                         // [73:60] clock_sequence,
                                                         // [121:74] node_id, rest 0
    output logic [uvp_pkg::STAT_W-1:0] o_m_axis_tuser    // [1:0] status
);
    import uvp_pkg::*;

    logic            r_in_valid;
    logic [IN_W-1:0] r_in_byte;
    logic            r_out_valid;
    t_result         r_out;
    logic            advance;
    t_char           dec;
    t_result         res;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    uvp_decode u_decode (
        .i_byte (r_in_byte),
        .o_char (dec)
    );

    uvp_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_char    (dec),
        .o_result  (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {{(OUT_W - NODE_W - CLK_W - TIME_W){1'b0}},
                              r_out.node_id, r_out.clock_sequence, r_out.time_value};

endmodule
